// File: rtl/pctd_pkg.sv
// pctd_pkg: shared types and constants for the prefix code table decoder.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package pctd_pkg;

    localparam int ACT_W     = 2;
    localparam int SYM_W     = 8;
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 32;
    localparam int BYTE_W    = 8;
    // compare width for accumulated length plus up to eight new bits (max 64 + 8)
    localparam int CMP_LEN_W = 7;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DATA  = 2'd2;

    // best-match bit position when nothing matched in a scan
    localparam logic [3:0] NO_MATCH = 4'd8;

    typedef struct packed {
        logic clear;
        logic load;
        logic byte_start;
        logic scan_start;
        logic scan_step;
        logic take_match;
        logic take_none;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic rem_done;
        logic pend_vld;
        logic out_free;
        logic stuck;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/pctd_in_if.sv
// pctd_in_if: input channel of the decoder (valid/ready plus item fields).
// Depends on pctd_pkg for field widths.
`default_nettype none

interface pctd_in_if;
    logic                          valid;
    logic                          ready;
    logic [pctd_pkg::ACT_W-1:0]    action;
    logic [pctd_pkg::SYM_W-1:0]    entry_symbol;
    logic [pctd_pkg::LEN_W-1:0]    entry_length;
    logic [pctd_pkg::CODE_W-1:0]   entry_code;
    logic [pctd_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, action, entry_symbol, entry_length, entry_code, data_byte,
                    input ready);
    modport sink   (input valid, action, entry_symbol, entry_length, entry_code, data_byte,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/pctd_out_if.sv
// pctd_out_if: result channel of the decoder (valid/ready, symbol, last).
// Depends on pctd_pkg for field widths.
`default_nettype none

interface pctd_out_if;
    logic                        valid;
    logic                        ready;
    logic [pctd_pkg::SYM_W-1:0]  symbol;
    logic                        last;

    modport source (output valid, symbol, last, input ready);
    modport sink   (input valid, symbol, last, output ready);
endinterface

`default_nettype wire

// File: rtl/pctd_ctrl.sv
// pctd_ctrl: sequencing state machine of the decoder.
// Depends on pctd_pkg (action codes, command and status structs).
`default_nettype none

module pctd_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic [pctd_pkg::ACT_W-1:0]  i_action,
    output logic                             o_in_ready,
    output pctd_pkg::t_dp_cmd                o_cmd,
    input  wire pctd_pkg::t_dp_sts           i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_action)
                        pctd_pkg::ACT_CLEAR: o_cmd.clear = 1'b1;
                        pctd_pkg::ACT_LOAD:  o_cmd.load  = 1'b1;
                        pctd_pkg::ACT_DATA: begin
                            if (!i_sts.stuck) begin
                                o_cmd.byte_start = 1'b1;
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.found) begin
                    // a held symbol moves to the output before the new one is held
                    if (!i_sts.pend_vld || i_sts.out_free) begin
                        o_cmd.take_match = 1'b1;
                        if (i_sts.rem_done) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                end else begin
                    o_cmd.take_none = 1'b1;
                    n_state         = i_sts.pend_vld ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pctd_dp.sv
// pctd_dp: decoder datapath - code table memory, valid bits, bit accumulator,
// eight-candidate compare against one table entry per cycle, result registers.
// Depends on pctd_pkg (widths, command and status structs).
`default_nettype none

module pctd_dp #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pctd_pkg::t_dp_cmd            i_cmd,
    output pctd_pkg::t_dp_sts                 o_sts,
    input  wire logic [pctd_pkg::SYM_W-1:0]   i_load_sym,
    input  wire logic [pctd_pkg::LEN_W-1:0]   i_load_len,
    input  wire logic [pctd_pkg::CODE_W-1:0]  i_load_code,
    input  wire logic [pctd_pkg::BYTE_W-1:0]  i_byte,
    output logic                              o_valid,
    input  wire logic                         i_out_ready,
    output logic [pctd_pkg::SYM_W-1:0]        o_symbol,
    output logic                              o_last
);

    localparam int SW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CNTW  = $clog2(NUM_SYMBOLS + 1);
    localparam int AW    = MAX_CODE_LEN;
    localparam int LW    = $clog2(MAX_CODE_LEN + 1);
    localparam int CW    = (AW > pctd_pkg::CODE_W) ? AW : pctd_pkg::CODE_W;
    localparam int CLW   = pctd_pkg::CMP_LEN_W;
    localparam int LENW  = pctd_pkg::LEN_W;
    localparam int CODEW = pctd_pkg::CODE_W;
    localparam int SYMW  = pctd_pkg::SYM_W;

    // table memory: {length, masked code}
    logic [LENW+CODEW-1:0] mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] r_vbits;

    logic [CNTW-1:0]  r_cnt;
    logic             r_rd_vld;
    logic             r_rd_vbit;
    logic [SW-1:0]    r_rd_sym;
    logic [LENW-1:0]  r_rd_len;
    logic [CODEW-1:0] r_rd_code;

    logic [AW-1:0]    r_acc;
    logic [LW-1:0]    r_len;
    logic             r_stuck;
    logic [7:0]       r_byte;
    logic [3:0]       r_rem;

    logic [3:0]       r_best_j;
    logic [SW-1:0]    r_best_sym;
    logic [SW-1:0]    r_pend_sym;
    logic             r_pend_vld;
    logic             r_out_valid;
    logic [SYMW-1:0]  r_out_sym;
    logic             r_out_last;

    logic [CW-1:0]    cand     [8];
    logic [CLW-1:0]   cand_len [8];
    logic [7:0]       hit;
    logic [3:0]       ent_j;
    logic [3:0]       jp1;
    logic [3:0]       rem_m1;
    logic [CLW-1:0]   grow_len;
    logic             grow_ovf;
    logic             out_free;
    logic             in_range;
    logic [32:0]      mask_ext;
    logic [CODEW-1:0] code_m;
    logic             scan_rd;

    assign in_range = {1'b0, i_load_sym} < 9'(NUM_SYMBOLS);
    assign mask_ext = (33'd1 << i_load_len) - 33'd1;
    assign code_m   = (i_load_len >= 6'd32) ? i_load_code : (i_load_code & mask_ext[31:0]);
    assign scan_rd  = i_cmd.scan_step && (r_cnt != CNTW'(NUM_SYMBOLS));

    // candidate j: accumulator extended by the next j+1 bits of the byte
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            cand[j]     = (CW'(r_acc) << (j + 1)) | CW'(r_byte >> (7 - j));
            cand_len[j] = CLW'(r_len) + CLW'(j + 1);
            hit[j]      = r_rd_vld && r_rd_vbit && (r_rd_len != '0)
                          && (CLW'(r_rd_len) == cand_len[j])
                          && (CW'(r_rd_code) == cand[j])
                          && (4'(j) < r_rem)
                          && (cand_len[j] <= CLW'(MAX_CODE_LEN));
        end
    end

    // earliest bit position at which this entry matches
    always_comb begin
        ent_j = pctd_pkg::NO_MATCH;
        for (int j = 7; j >= 0; j--) begin
            if (hit[j]) begin
                ent_j = 4'(j);
            end
        end
    end

    assign jp1      = {1'b0, r_best_j[2:0]} + 4'd1;
    assign rem_m1   = r_rem - 4'd1;
    assign grow_len = CLW'(r_len) + CLW'(r_rem);
    assign grow_ovf = grow_len > CLW'(MAX_CODE_LEN);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_range) begin
            mem[i_load_sym[SW-1:0]] <= {i_load_len, code_m};
        end
        if (scan_rd) begin
            {r_rd_len, r_rd_code} <= mem[r_cnt[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_rd) begin
            r_rd_vbit <= r_vbits[r_cnt[SW-1:0]];
            r_rd_sym  <= r_cnt[SW-1:0];
        end
        if (i_cmd.byte_start) begin
            r_byte <= i_byte;
        end else if (i_cmd.take_match) begin
            r_byte <= r_byte << jp1;
        end
        if (i_cmd.take_match) begin
            r_pend_sym <= r_best_sym;
        end
        if (i_cmd.take_match && r_pend_vld) begin
            r_out_sym  <= SYMW'(r_pend_sym);
            r_out_last <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_sym  <= SYMW'(r_pend_sym);
            r_out_last <= 1'b1;
        end
        if (!i_cmd.scan_start && (ent_j < r_best_j)) begin
            r_best_sym <= r_rd_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits     <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_acc       <= '0;
            r_len       <= '0;
            r_stuck     <= 1'b0;
            r_rem       <= '0;
            r_best_j    <= pctd_pkg::NO_MATCH;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_vbits <= '0;
            end else if (i_cmd.load && in_range) begin
                r_vbits[i_load_sym[SW-1:0]] <= 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_cnt    <= '0;
                r_rd_vld <= 1'b0;
                r_best_j <= pctd_pkg::NO_MATCH;
            end else begin
                if (i_cmd.scan_step) begin
                    r_rd_vld <= scan_rd;
                    if (scan_rd) begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                if (ent_j < r_best_j) begin
                    r_best_j <= ent_j;
                end
            end

            if (i_cmd.byte_start) begin
                r_rem <= 4'd8;
            end else if (i_cmd.take_match) begin
                r_rem <= r_rem - jp1;
            end

            if (i_cmd.clear) begin
                r_acc   <= '0;
                r_len   <= '0;
                r_stuck <= 1'b0;
            end else if (i_cmd.take_match) begin
                r_acc <= '0;
                r_len <= '0;
            end else if (i_cmd.take_none) begin
                if (grow_ovf) begin
                    r_stuck <= 1'b1;
                    r_acc   <= '0;
                    r_len   <= '0;
                end else begin
                    r_acc <= cand[rem_m1[2:0]][AW-1:0];
                    r_len <= LW'(grow_len);
                end
            end

            if (i_cmd.take_match) begin
                r_pend_vld <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
            end

            if ((i_cmd.take_match && r_pend_vld) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.scan_last = i_cmd.scan_step && (r_cnt == CNTW'(NUM_SYMBOLS));
    assign o_sts.found     = (r_best_j != pctd_pkg::NO_MATCH);
    assign o_sts.rem_done  = (r_rem == jp1);
    assign o_sts.pend_vld  = r_pend_vld;
    assign o_sts.out_free  = out_free;
    assign o_sts.stuck     = r_stuck;

    assign o_valid  = r_out_valid;
    assign o_symbol = r_out_sym;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire

// File: rtl/prefix_code_table_decoder.sv
// Prefix code decoder. Clear and table load are carried out on their input transfer.
// A data byte is decoded by one table scan per decoded symbol (one entry read per cycle,
// eight bit positions compared per entry), plus one more scan when bits remain unmatched,
// plus a release of the final symbol, and takes longer while the output stalls; no new
// item is accepted until it is done. When stuck, a data byte is accepted and dropped.
// Reset (synchronous, active low) empties the table valid bits, accumulator and sticky flag.
`default_nettype none

module prefix_code_table_decoder #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pctd_in_if.sink     i_in,
    pctd_out_if.source  o_out
);

    pctd_pkg::t_dp_cmd cmd;
    pctd_pkg::t_dp_sts sts;

    pctd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    pctd_dp #(
        .NUM_SYMBOLS  (NUM_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_load_sym  (i_in.entry_symbol),
        .i_load_len  (i_in.entry_length),
        .i_load_code (i_in.entry_code),
        .i_byte      (i_in.data_byte),
        .o_valid     (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_symbol    (o_out.symbol),
        .o_last      (o_out.last)
    );

`ifndef SYNTHESIS
    a_flush_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |-> sts.out_free)
        else $error("final symbol released over an untaken result");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.take_match && sts.pend_vld) |-> sts.out_free)
        else $error("held symbol pushed over an untaken result");

    a_no_decode_when_stuck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.byte_start |-> !sts.stuck)
        else $error("byte decode started with sticky overflow set");

    a_clear_unsticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.action == pctd_pkg::ACT_CLEAR)) |=> !sts.stuck)
        else $error("sticky overflow survived a clear");
`endif

endmodule

`default_nettype wire
